### hw/rtl/udprx_pkg.sv
// udprx_pkg: shared types, sizes and codes for the udp receive check and port demux
// no dependencies
`timescale 1ns / 1ps

package udprx_pkg;

  localparam int TABLE_SLOTS = 8;
  localparam int SLOT_W      = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int CNT_W       = $clog2(TABLE_SLOTS + 1);

  localparam logic [15:0] HDR_BYTES = 16'd8;
  localparam logic [15:0] PROTO_UDP = 16'd17;

  localparam logic MODE_BIND = 1'b0;
  localparam logic MODE_BYTE = 1'b1;

  localparam logic KIND_BIND    = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  localparam logic [2:0] BIND_OK        = 3'd0;
  localparam logic [2:0] BIND_PORT_ZERO = 3'd1;
  localparam logic [2:0] BIND_DUPLICATE = 3'd2;
  localparam logic [2:0] BIND_FULL      = 3'd3;

  localparam logic [2:0] VERD_DELIVERED   = 3'd0;
  localparam logic [2:0] VERD_SHORT       = 3'd1;
  localparam logic [2:0] VERD_BAD_LEN     = 3'd2;
  localparam logic [2:0] VERD_BAD_CKSUM   = 3'd3;
  localparam logic [2:0] VERD_NO_LISTENER = 3'd4;

  typedef struct packed {
    logic        mode;
    logic [15:0] bind_port;
    logic [7:0]  data_byte;
    logic        last;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
  } in_t;

  typedef struct packed {
    logic        kind;
    logic [2:0]  status;
    logic [2:0]  slot;
    logic [31:0] sender_ip;
    logic [15:0] source_port;
    logic [15:0] dest_port;
    logic [15:0] data_len;
  } out_t;

  typedef struct packed {
    logic [16:0] count;
    logic [31:0] sum;
    logic [7:0]  held;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [15:0] ulen;
    logic [15:0] cksum;
  } seg_state_t;

endpackage

### hw/rtl/udp_rx_check_and_port_demux.sv
// udp_rx_check_and_port_demux: top level, request control, port table sweep and result register
// depends on udprx_pkg, udprx_seg_acc, udprx_csum, udprx_port_ram
`timescale 1ns / 1ps

// Segment bytes are taken one per cycle; in_ready stays high through a segment,
// also while an earlier result waits on the output. Lookups walk the port
// table memory one slot per cycle through its single read port, so a bind
// request holds in_ready low until its result is registered, and the final
// byte of a segment likewise (four checksum pipeline stages ahead of the
// table walk). Each bind request and each final byte yields exactly one
// result; a result that is not taken holds the block in its last step.

module udp_rx_check_and_port_demux import udprx_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_CKWAIT = 2'd1;
  localparam logic [1:0] ST_SWEEP  = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

  logic [1:0]        state_r, state_nxt;
  logic              in_acc, bind_acc, last_acc;
  seg_state_t        seg_nxt;
  seg_state_t        snap_r;
  logic [31:0]       sip_r;
  logic              op_r;
  logic [15:0]       key_r;
  logic              ck_done, ck_ok;
  logic [CNT_W-1:0]  cnt_r;
  logic              cmp_v_r;
  logic [SLOT_W-1:0] cmp_idx_r;
  logic              hit_r, free_r;
  logic [SLOT_W-1:0] hit_idx_r, free_idx_r;
  logic [TABLE_SLOTS-1:0] valid_r;
  logic              rd_en;
  logic [15:0]       rd_data;
  logic              cmp_hit, cmp_free, cmp_last;
  logic              out_valid_r;
  out_t              out_r, res;
  logic              finish_go, bind_ok;
  logic [SLOT_W+2:0] hit_wide, free_wide;

  assign in_ready = (state_r == ST_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign bind_acc = in_acc && (in_data.mode == MODE_BIND);
  assign last_acc = in_acc && (in_data.mode == MODE_BYTE) && in_data.last;

  udprx_seg_acc u_seg (
    .clk       (clk),
    .rst_n     (rst_n),
    .byte_en   (in_acc && (in_data.mode == MODE_BYTE)),
    .last      (in_data.last),
    .data_byte (in_data.data_byte),
    .seg_nxt   (seg_nxt)
  );

  udprx_csum u_csum (
    .clk   (clk),
    .rst_n (rst_n),
    .start (last_acc),
    .seg   (seg_nxt),
    .sip   (in_data.src_ip),
    .dip   (in_data.dst_ip),
    .done  (ck_done),
    .ok    (ck_ok)
  );

  assign rd_en = (state_r == ST_SWEEP) && (cnt_r < CNT_W'(TABLE_SLOTS));

  udprx_port_ram u_ram (
    .clk     (clk),
    .wr_en   (finish_go && bind_ok),
    .wr_addr (free_idx_r),
    .wr_data (key_r),
    .rd_en   (rd_en),
    .rd_addr (cnt_r[SLOT_W-1:0]),
    .rd_data (rd_data)
  );

  assign cmp_hit  = cmp_v_r && valid_r[cmp_idx_r] && (rd_data == key_r);
  assign cmp_free = cmp_v_r && !valid_r[cmp_idx_r];
  assign cmp_last = cmp_v_r && (cmp_idx_r == SLOT_W'(TABLE_SLOTS - 1));

  assign finish_go = (state_r == ST_FINISH) && (!out_valid_r || out_ready);
  assign bind_ok   = (op_r == MODE_BIND) && (key_r != 16'h0000) && !hit_r && free_r;
  assign hit_wide  = {3'b000, hit_idx_r};
  assign free_wide = {3'b000, free_idx_r};

  always_comb begin
    res = '0;
    if (op_r == MODE_BIND) begin
      res.kind = KIND_BIND;
      if (key_r == 16'h0000) begin
        res.status = BIND_PORT_ZERO;
      end else if (hit_r) begin
        res.status = BIND_DUPLICATE;
      end else if (!free_r) begin
        res.status = BIND_FULL;
      end else begin
        res.status = BIND_OK;
        res.slot   = free_wide[2:0];
      end
    end else begin
      res.kind = KIND_VERDICT;
      if (snap_r.count < 17'd8) begin
        res.status = VERD_SHORT;
      end else if ((snap_r.ulen < HDR_BYTES) || (snap_r.count < {1'b0, snap_r.ulen})
                   || snap_r.count[16]) begin
        res.status = VERD_BAD_LEN;
      end else if ((snap_r.cksum != 16'h0000) && !ck_ok) begin
        res.status = VERD_BAD_CKSUM;
      end else if (hit_r) begin
        res.status      = VERD_DELIVERED;
        res.slot        = hit_wide[2:0];
        res.sender_ip   = sip_r;
        res.source_port = snap_r.sport;
        res.dest_port   = snap_r.dport;
        res.data_len    = snap_r.ulen - HDR_BYTES;
      end else begin
        res.status = VERD_NO_LISTENER;
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (bind_acc) begin
          state_nxt = ST_SWEEP;
        end else if (last_acc) begin
          state_nxt = ST_CKWAIT;
        end
      end
      ST_CKWAIT: begin
        if (ck_done) begin
          state_nxt = ST_SWEEP;
        end
      end
      ST_SWEEP: begin
        if (cmp_last) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (finish_go) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
      cmp_v_r     <= 1'b0;
      cnt_r       <= '0;
      hit_r       <= 1'b0;
      free_r      <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (finish_go) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (finish_go && bind_ok) begin
        valid_r[free_idx_r] <= 1'b1;
      end
      if (in_acc) begin
        cnt_r   <= '0;
        cmp_v_r <= 1'b0;
        hit_r   <= 1'b0;
        free_r  <= 1'b0;
      end else begin
        cmp_v_r <= rd_en;
        if (rd_en) begin
          cnt_r <= cnt_r + CNT_W'(1);
        end
        // lowest matching and lowest free slot win
        if (cmp_hit && !hit_r) begin
          hit_r <= 1'b1;
        end
        if (cmp_free && !free_r) begin
          free_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx_r <= cnt_r[SLOT_W-1:0];
    if (cmp_hit && !hit_r) begin
      hit_idx_r <= cmp_idx_r;
    end
    if (cmp_free && !free_r) begin
      free_idx_r <= cmp_idx_r;
    end
    if (bind_acc) begin
      op_r  <= MODE_BIND;
      key_r <= in_data.bind_port;
    end else if (last_acc) begin
      op_r   <= MODE_BYTE;
      key_r  <= seg_nxt.dport;
      snap_r <= seg_nxt;
      sip_r  <= in_data.src_ip;
    end
    if (finish_go) begin
      out_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

### hw/rtl/udprx_port_ram.sv
// udprx_port_ram: bound port table, one write port and one registered read port
// depends on udprx_pkg
`timescale 1ns / 1ps

module udprx_port_ram import udprx_pkg::*; (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [SLOT_W-1:0] wr_addr,
  input  logic [15:0]       wr_data,
  input  logic              rd_en,
  input  logic [SLOT_W-1:0] rd_addr,
  output logic [15:0]       rd_data
);

  logic [15:0] mem [TABLE_SLOTS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### hw/rtl/udprx_seg_acc.sv
// udprx_seg_acc: per-segment byte counter, header capture and running word sum
// depends on udprx_pkg
`timescale 1ns / 1ps

module udprx_seg_acc import udprx_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       byte_en,
  input  logic       last,
  input  logic [7:0] data_byte,
  output seg_state_t seg_nxt
);

  seg_state_t  seg_r;
  logic [16:0] idx;

  assign idx = seg_r.count;

  always_comb begin
    seg_nxt = seg_r;
    if (idx < 17'd8) begin
      case (idx[2:0])
        3'd0: seg_nxt.sport = {data_byte, 8'h00};
        3'd1: seg_nxt.sport = seg_r.sport | {8'h00, data_byte};
        3'd2: seg_nxt.dport = {data_byte, 8'h00};
        3'd3: seg_nxt.dport = seg_r.dport | {8'h00, data_byte};
        3'd4: seg_nxt.ulen  = {data_byte, 8'h00};
        3'd5: seg_nxt.ulen  = seg_r.ulen | {8'h00, data_byte};
        3'd6: seg_nxt.cksum = {data_byte, 8'h00};
        default: seg_nxt.cksum = seg_r.cksum | {8'h00, data_byte};
      endcase
    end
    // bytes past the udp length are counted but not summed, apart from the first six
    if ((idx < 17'd6) || (idx < {1'b0, seg_r.ulen})) begin
      if (!idx[0]) begin
        seg_nxt.held = data_byte;
      end else begin
        seg_nxt.sum = seg_r.sum + {16'h0000, seg_r.held, data_byte};
      end
    end
    if (!seg_r.count[16]) begin
      seg_nxt.count = seg_r.count + 17'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_r <= '0;
    end else if (byte_en) begin
      seg_r <= last ? '0 : seg_nxt;
    end
  end

endmodule

### hw/rtl/udprx_csum.sv
// udprx_csum: pipelined pseudo-header add and ones' complement fold
// depends on udprx_pkg
`timescale 1ns / 1ps

module udprx_csum import udprx_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  seg_state_t  seg,
  input  logic [31:0] sip,
  input  logic [31:0] dip,
  output logic        done,
  output logic        ok
);

  logic [31:0] s1_r, s2_r, s3_r;
  logic [15:0] sip_lo_r, dip_lo_r, dip_lo2_r, dip_hi_r;
  logic [15:0] ulen_r, ulen2_r;
  logic        v1_r, v2_r, v3_r, done_r, ok_r;
  logic [31:0] pad;
  logic [16:0] fold1;
  logic [15:0] fold2;

  // odd length: last byte is the high half of a padded word
  assign pad   = seg.ulen[0] ? {16'h0000, seg.held, 8'h00} : 32'd0;
  assign fold1 = {1'b0, s3_r[15:0]} + {1'b0, s3_r[31:16]};
  assign fold2 = fold1[15:0] + {15'd0, fold1[16]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      v3_r   <= 1'b0;
      done_r <= 1'b0;
    end else begin
      v1_r   <= start;
      v2_r   <= v1_r;
      v3_r   <= v2_r;
      done_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      s1_r     <= seg.sum + pad + {16'h0000, sip[31:16]};
      sip_lo_r <= sip[15:0];
      dip_hi_r <= dip[31:16];
      dip_lo_r <= dip[15:0];
      ulen_r   <= seg.ulen;
    end
    if (v1_r) begin
      s2_r      <= s1_r + {16'h0000, sip_lo_r} + {16'h0000, dip_hi_r};
      dip_lo2_r <= dip_lo_r;
      ulen2_r   <= ulen_r;
    end
    if (v2_r) begin
      s3_r <= s2_r + {16'h0000, dip_lo2_r} + {16'h0000, PROTO_UDP} + {16'h0000, ulen2_r};
    end
    if (v3_r) begin
      ok_r <= (fold2 == 16'hFFFF);
    end
  end

  assign done = done_r;
  assign ok   = ok_r;

endmodule
